FILE: hdl/pfsp_pkg.sv
package pfsp_pkg;

  localparam int unsigned ValueBits = 31;
  localparam logic [ValueBits-1:0] ValueMax = '1;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSharp  = 8'h23;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharOne    = 8'h31;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharPeriod = 8'h2e;
  localparam logic [7:0] CharComma  = 8'h2c;
  localparam logic [7:0] CharSemi   = 8'h3b;
  localparam logic [7:0] CharColon  = 8'h3a;
  localparam logic [7:0] CharUnder  = 8'h5f;
  localparam logic [7:0] CharZ      = 8'h7a;
  localparam logic [7:0] CharL      = 8'h6c;
  localparam logic [7:0] CharH      = 8'h68;

  localparam logic [2:0] CountMax = 3'd7;

  typedef enum logic [2:0] {
    MODE_SCAN,
    MODE_WSTART,
    MODE_WACC,
    MODE_PSTART,
    MODE_PACC
  } mode_e;

  // input transaction, ch in the low byte
  typedef struct packed {
    logic signed [31:0] star_arg;
    logic [7:0]         ch;
  } in_item_t;

  // result transaction, conversion_char in the low byte
  typedef struct packed {
    logic [4:0]  pad;
    logic [30:0] precision;
    logic [30:0] field_width;
    logic        precision_given;
    logic        zero_pad;
    logic        left_justify;
    logic [2:0]  short_count;
    logic [2:0]  long_count;
    logic        size_z;
    logic        alt_form;
    logic        space_sign;
    logic        plus_sign;
    logic [7:0]  conversion_char;
  } result_t;

  // acc * 10 + digit, saturating
  function automatic logic [ValueBits-1:0] acc_digit(input logic [ValueBits-1:0] acc,
                                                     input logic [3:0] digit);
    logic [ValueBits+3:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ValueBits{1'b0}}, digit};
    acc_digit = (v > {4'b0000, ValueMax}) ? ValueMax : v[ValueBits-1:0];
  endfunction

  // magnitude of a star width, saturating
  function automatic logic [ValueBits-1:0] star_mag(input logic signed [31:0] a);
    logic [31:0] mag;
    mag = a[31] ? (~a + 32'd1) : a;
    star_mag = (mag > 32'(ValueMax)) ? ValueMax : mag[ValueBits-1:0];
  endfunction

endpackage

FILE: hdl/printf_format_spec_parser.sv
// Format specifier parser: takes the characters after a percent sign, one per
// slave transaction (tdata: ch [7:0], star_arg [39:8]), and emits one master
// transaction per finished specifier with its flags, length modifiers, width
// and precision. A character that cannot continue the specifier, NUL
// included, ends it; that character is reported as conversion_char and the
// parser returns to its initial state for the next specifier.
// A result is registered: the terminating character is taken into the input
// register and then processed into the result register, which presents the
// master transaction. Throughput: one character per cycle while the receiver
// takes results; each step is one decode plus one saturating multiply-by-ten
// accumulate between the two registers.
// Reset clears the parse state and both valid flags; tready is high right after.
// When the receiver stalls, the result register holds its transaction and
// the input register takes one more character and holds it, then tready
// drops until the waiting result transaction is taken.
module printf_format_spec_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // ch [7:0], star_arg [39:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o   // conversion_char [7:0], plus_sign [8],
                                       // space_sign [9], alt_form [10], size_z [11],
                                       // long_count [14:12], short_count [17:15],
                                       // left_justify [18], zero_pad [19],
                                       // precision_given [20], field_width [51:21],
                                       // precision [82:52], zero [87:83]
);
  import pfsp_pkg::*;

  logic     in_valid_q;
  in_item_t in_q;
  logic     out_valid_q;
  result_t  out_q;
  logic     advance;

  mode_e                  mode_q, mode_d;
  logic [ValueBits-1:0]   acc_q, acc_d;
  logic [ValueBits-1:0]   width_q, width_d;
  logic signed [31:0]     prec_q, prec_d;
  logic plus_q, plus_d, space_q, space_d, sharp_q, sharp_d, z_q, z_d;
  logic left_q, left_d, zero_q, zero_d, period_q, period_d;
  logic [2:0] lcnt_q, lcnt_d, hcnt_q, hcnt_d;

  logic                 emit;
  result_t              res;
  logic [7:0]           c;
  logic                 is_digit;
  logic [ValueBits-1:0] acc_next;
  logic                 do_scan;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= in_item_t'(s_axis_tdata_i);
    end
  end

  assign c        = in_q.ch;
  assign is_digit = (c >= CharZero) && (c <= CharNine);
  // one shared accumulate: runs continue from acc_q, new runs start at zero
  assign acc_next = acc_digit((mode_q == MODE_WACC || mode_q == MODE_PACC) ? acc_q : '0,
                              4'(c - CharZero));

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    width_d  = width_q;
    prec_d   = prec_q;
    plus_d   = plus_q;
    space_d  = space_q;
    sharp_d  = sharp_q;
    z_d      = z_q;
    left_d   = left_q;
    zero_d   = zero_q;
    period_d = period_q;
    lcnt_d   = lcnt_q;
    hcnt_d   = hcnt_q;
    do_scan  = 1'b0;
    emit     = 1'b0;
    res      = '0;

    case (mode_q)
      MODE_WSTART: begin
        if (c == CharStar) begin
          if (in_q.star_arg[31]) left_d = 1'b1;
          width_d = star_mag(in_q.star_arg);
          mode_d  = MODE_SCAN;
        end else if (is_digit) begin
          acc_d  = acc_next;
          mode_d = MODE_WACC;
        end else begin
          mode_d  = MODE_SCAN;
          do_scan = 1'b1;
        end
      end
      MODE_WACC: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else begin
          // a zero run keeps the earlier width
          if (acc_q != '0) width_d = acc_q;
          acc_d   = '0;
          mode_d  = MODE_SCAN;
          do_scan = 1'b1;
        end
      end
      MODE_PSTART: begin
        if (c == CharStar) begin
          prec_d = in_q.star_arg;
          mode_d = MODE_SCAN;
        end else if (is_digit) begin
          acc_d  = acc_next;
          mode_d = MODE_PACC;
        end else begin
          prec_d  = '0;
          mode_d  = MODE_SCAN;
          do_scan = 1'b1;
        end
      end
      MODE_PACC: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else begin
          prec_d  = 32'(acc_q);
          acc_d   = '0;
          mode_d  = MODE_SCAN;
          do_scan = 1'b1;
        end
      end
      default: begin
        mode_d  = MODE_SCAN;
        do_scan = 1'b1;
      end
    endcase

    if (do_scan) begin
      case (c)
        CharSharp: sharp_d = 1'b1;
        CharPlus:  plus_d  = 1'b1;
        CharSpace: space_d = 1'b1;
        CharZ:     z_d     = 1'b1;
        CharL:     if (lcnt_q != CountMax) lcnt_d = lcnt_q + 3'd1;
        CharH:     if (hcnt_q != CountMax) hcnt_d = hcnt_q + 3'd1;
        CharComma, CharSemi, CharColon, CharUnder: ;
        CharMinus: begin
          left_d = 1'b1;
          mode_d = MODE_WSTART;
        end
        CharZero: begin
          zero_d = 1'b1;
          mode_d = MODE_WSTART;
        end
        CharStar: begin
          if (in_q.star_arg[31]) left_d = 1'b1;
          width_d = star_mag(in_q.star_arg);
        end
        CharPeriod: begin
          period_d = 1'b1;
          mode_d   = MODE_PSTART;
        end
        default: begin
          if (c inside {[CharOne:CharNine]}) begin
            acc_d  = acc_next;
            mode_d = MODE_WACC;
          end else begin
            emit                = 1'b1;
            res.conversion_char = c;
            res.plus_sign       = plus_d;
            res.space_sign      = space_d;
            res.alt_form        = sharp_d;
            res.size_z          = z_d;
            res.long_count      = lcnt_d;
            res.short_count     = hcnt_d;
            res.left_justify    = left_d;
            res.zero_pad        = zero_d;
            res.field_width     = 31'(width_d);
            if (prec_d[31]) begin
              res.precision_given = 1'b0;
              res.precision       = '0;
            end else begin
              res.precision_given = period_d;
              res.precision       = (prec_d[30:0] > 31'(ValueMax)) ? 31'(ValueMax)
                                                                     : prec_d[30:0];
            end
            mode_d   = MODE_SCAN;
            acc_d    = '0;
            width_d  = '0;
            prec_d   = '0;
            plus_d   = 1'b0;
            space_d  = 1'b0;
            sharp_d  = 1'b0;
            z_d      = 1'b0;
            left_d   = 1'b0;
            zero_d   = 1'b0;
            period_d = 1'b0;
            lcnt_d   = '0;
            hcnt_d   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SCAN;
      acc_q    <= '0;
      width_q  <= '0;
      prec_q   <= '0;
      plus_q   <= 1'b0;
      space_q  <= 1'b0;
      sharp_q  <= 1'b0;
      z_q      <= 1'b0;
      left_q   <= 1'b0;
      zero_q   <= 1'b0;
      period_q <= 1'b0;
      lcnt_q   <= '0;
      hcnt_q   <= '0;
    end else if (advance) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      width_q  <= width_d;
      prec_q   <= prec_d;
      plus_q   <= plus_d;
      space_q  <= space_d;
      sharp_q  <= sharp_d;
      z_q      <= z_d;
      left_q   <= left_d;
      zero_q   <= zero_d;
      period_q <= period_d;
      lcnt_q   <= lcnt_d;
      hcnt_q   <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // the accumulator only holds a value inside a digit run
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SCAN || mode_q == MODE_WSTART || mode_q == MODE_PSTART)
      |-> acc_q == '0)
    else $error("digit accumulator not cleared outside a digit run");

  // an empty input register always takes a character
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty input register");

  // a new result only appears from a processed character
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result appeared without a processed character");

  // a finished specifier leaves the parser in its initial state
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (mode_q == MODE_SCAN && width_q == '0 && !period_q))
    else $error("parse state not cleared after a result");

endmodule
